/* src/irvc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package irvc_pkg;

    // table size and pile width
    localparam int MAX_RULES = 1024;
    localparam int PILE_BITS = 64;

    // derived widths
    localparam int RULE_AW  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int COUNT_W  = $clog2(MAX_RULES + 1);
    localparam int ACT_W    = 7;
    localparam int TGT_W    = 6;
    localparam int VEC_W    = 64;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(64);
    localparam logic [ACT_W-1:0] PILE_LIMIT   = ACT_W'(PILE_BITS);

    // positions at or above the pile width are ignored
    localparam logic [VEC_W-1:0] PILE_MASK =
        (PILE_BITS >= VEC_W) ? {VEC_W{1'b1}} :
        ((VEC_W'(1) << (PILE_BITS % VEC_W)) - VEC_W'(1));

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [VEC_W-1:0] premise_mask;
        logic [TGT_W-1:0] target_index;
        logic [VEC_W-1:0] pile_bits;
    } in_item_t;

    typedef struct packed {
        logic rejected;
        logic load_dropped;
    } out_item_t;

    typedef struct packed {
        logic [VEC_W-1:0] premise;
        logic [TGT_W-1:0] target;
    } rule_t;

    localparam int RULE_W = $bits(rule_t);

endpackage

`default_nettype wire

/* src/irvc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module irvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/irvc_match.sv */
`timescale 1ns / 1ps
`default_nettype none

module irvc_match (
    input  wire logic [irvc_pkg::VEC_W-1:0] pile,
    input  wire irvc_pkg::rule_t            rule,
    output logic                            violated
);

    import irvc_pkg::*;

    logic premises_met;
    logic target_clear;

    // all premise positions present, implied position absent
    assign premises_met = ((pile & rule.premise) == rule.premise);
    assign target_clear = !pile[rule.target];
    assign violated     = premises_met && target_clear;

endmodule

`default_nettype wire

/* src/implication_rule_violation_check_top.sv */
// Implication rule checker. A load item (kind 0) appends one rule, a premise
// bitmask plus one target position, to a table of up to MAX_RULES entries; it
// answers in the next cycle with load_dropped set when the table is full or the
// target is not below active_bits (saturated at PILE_BITS). A query item
// (kind 1) carries a pile vector and answers rejected=1 when some stored rule
// has all its premise bits present and its target bit absent. A query scans
// the table through a single read port of the rule memory, one rule a cycle;
// a query on an empty table answers in the next cycle. The input side stalls
// while a scan runs. The user must write active_bits only while the block is idle;
// the block does not enforce this. After reset active_bits reads 64 and the table is empty.
`timescale 1ns / 1ps
`default_nettype none

module implication_rule_violation_check_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [irvc_pkg::ACT_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire irvc_pkg::in_item_t            in_item,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output irvc_pkg::out_item_t                out_item
);

    import irvc_pkg::*;

    // scan sequencer
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_LAST = 3'b100
    } state_t;

    state_t              state_reg,       state_next;
    logic [COUNT_W-1:0]  count_reg,       count_next;
    logic [COUNT_W-1:0]  idx_reg,         idx_next;
    logic                hit_reg,         hit_next;
    logic                rd_valid_reg,    rd_valid_next;
    logic                out_valid_reg,   out_valid_next;
    out_item_t           out_item_reg,    out_item_next;
    logic [VEC_W-1:0]    pile_reg,        pile_next;
    logic [ACT_W-1:0]    active_bits_reg;

    logic               accept;
    logic [ACT_W-1:0]   limit;
    logic               target_ok;
    logic               table_full;
    logic               load_fits;
    logic [COUNT_W-1:0] last_idx;

    logic               ram_re;
    logic [RULE_W-1:0]  ram_rdata;
    rule_t              new_rule;
    rule_t              rd_rule;
    logic               violated;

    // active bit count saturates at the pile width
    assign limit      = (active_bits_reg > PILE_LIMIT) ? PILE_LIMIT : active_bits_reg;
    assign target_ok  = ({1'b0, in_item.target_index} < limit);
    assign table_full = (count_reg >= COUNT_W'(MAX_RULES));

    // take a new item only when idle and the result slot is free or leaving
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign load_fits = accept && (in_item.kind == KIND_LOAD) && target_ok && !table_full;
    assign last_idx  = COUNT_W'(count_reg - 1'b1);

    assign new_rule.premise = in_item.premise_mask & PILE_MASK;
    assign new_rule.target  = in_item.target_index;
    assign rd_rule          = rule_t'(ram_rdata);

    // rule table, appended at the fill count
    irvc_ram #(
        .WIDTH (RULE_W),
        .DEPTH (MAX_RULES)
    ) u_rules (
        .clk   (clk),
        .we    (load_fits),
        .waddr (count_reg[RULE_AW-1:0]),
        .wdata (new_rule),
        .re    (ram_re),
        .raddr (idx_reg[RULE_AW-1:0]),
        .rdata (ram_rdata)
    );

    // shared compare unit, one rule per cycle
    irvc_match u_match (
        .pile     (pile_reg),
        .rule     (rd_rule),
        .violated (violated)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        rd_valid_next  = 1'b0;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        pile_next      = pile_reg;
        ram_re         = 1'b0;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.kind == KIND_LOAD)
                    begin
                        // load answers at once
                        out_valid_next             = 1'b1;
                        out_item_next.rejected     = 1'b0;
                        out_item_next.load_dropped = !(target_ok && !table_full);
                        if (target_ok && !table_full)
                        begin
                            count_next = COUNT_W'(count_reg + 1'b1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // nothing stored, nothing violated
                        out_valid_next = 1'b1;
                        out_item_next  = '0;
                    end
                    else
                    begin
                        pile_next  = in_item.pile_bits & PILE_MASK;
                        idx_next   = '0;
                        hit_next   = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one read, check the rule read the cycle before
                ram_re        = 1'b1;
                rd_valid_next = 1'b1;
                if (rd_valid_reg)
                begin
                    hit_next = hit_reg | violated;
                end
                idx_next = COUNT_W'(idx_reg + 1'b1);
                if (idx_reg == last_idx)
                begin
                    state_next = S_LAST;
                end
            end

            S_LAST:
            begin
                // last rule's data is on the read port now
                out_valid_next             = 1'b1;
                out_item_next.rejected     = hit_reg | (rd_valid_reg & violated);
                out_item_next.load_dropped = 1'b0;
                state_next                 = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            idx_reg         <= '0;
            hit_reg         <= 1'b0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            active_bits_reg <= ACTIVE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                active_bits_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        pile_reg     <= pile_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

/* src/irvc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module irvc_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire irvc_pkg::out_item_t  out_item
);

    import irvc_pkg::*;

    // a held result keeps its valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a waiting result blocks new items
    a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("item taken while result waits");

    // an accepted item either answers next cycle or holds the input off
    a_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid || in_stall)
        else $error("item accepted but block went idle");

    // a result is never both a reject and a dropped load
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.rejected && out_item.load_dropped))
        else $error("both result flags set");

endmodule

bind implication_rule_violation_check_top irvc_checker u_irvc_checker (.*);

`default_nettype wire
